[hdl/cole_pkg.sv]
// ----------------------------------------------------------------------------
// cole_pkg
// Types and codes shared by the circular ordered list engine.
// ----------------------------------------------------------------------------
package cole_pkg;

	localparam logic [3:0] MODE_CLEAR  = 4'd0;
	localparam logic [3:0] MODE_FRONT  = 4'd1;
	localparam logic [3:0] MODE_END    = 4'd2;
	localparam logic [3:0] MODE_BEFORE = 4'd3;
	localparam logic [3:0] MODE_DROP_F = 4'd4;
	localparam logic [3:0] MODE_DROP_L = 4'd5;
	localparam logic [3:0] MODE_DROP_K = 4'd6;
	localparam logic [3:0] MODE_SEARCH = 4'd7;
	localparam logic [3:0] MODE_LIST   = 4'd8;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic        [3:0]  mode;
		logic signed [31:0] new_value;
		logic signed [31:0] key;
	} cole_in_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] item_value;
		logic        [4:0]  entry_count;
		logic               last;
	} cole_out_t;

endpackage

[hdl/circular_ordered_list_engine.sv]
// ----------------------------------------------------------------------------
// circular_ordered_list_engine
// Circular singly linked list of signed 32-bit values in a fixed node pool.
// ----------------------------------------------------------------------------
// One request is taken at a time. Front/end inserts, drop first, clear and
// unused modes register their word in S_DO and raise out_valid from S_OUT
// (clear rebuilds all links at once, as the link store is flip-flops). Key
// search, insert before key, drop key, drop last and listing walk the links
// one node per cycle through a single compare/step unit; a list request also
// waits on the output side for each of its words. in is stalled while a
// request is in progress or its last word waits in the output register.
module circular_ordered_list_engine
	import cole_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  cole_in_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output cole_out_t out_word
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_WALK = 5'b00010,
		S_DO   = 5'b00100,
		S_LIST = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [IW-1:0] link_q [CAPACITY];
	logic [IW-1:0] head_q, tail_q, free_q, cur_q, prev_q;
	logic [CW-1:0] occ_q, step_q;
	cole_in_t req_q;
	logic found_q;
	cole_out_t out_q;
	logic out_valid_q;

	// value store: written at insert, read at the walk pointer
	logic [31:0] val_mem [CAPACITY];
	logic [31:0] cur_val;
	assign cur_val = val_mem[cur_q];

	logic [4:0] occ5;
	assign occ5 = 5'(occ_q);

	assign in_stall  = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	logic walk_hit;
	assign walk_hit = (req_q.mode == MODE_DROP_L) ? (link_q[cur_q] == tail_q)
	                                              : (cur_val == req_q.key);

	// found_q high means the key walk missed
	logic do_insert, do_remove;
	assign do_insert = (req_q.mode == MODE_FRONT || req_q.mode == MODE_END
	                    || (req_q.mode == MODE_BEFORE && occ_q != '0 && !found_q))
	                   && occ_q != CW'(CAPACITY);
	assign do_remove = (req_q.mode == MODE_DROP_F || req_q.mode == MODE_DROP_L
	                    || (req_q.mode == MODE_DROP_K && !found_q))
	                   && occ_q != '0;

	cole_out_t do_word;
	always_comb begin
		do_word = '{ST_OK, 32'sd0, occ5, 1'b1};
		if (do_insert) begin
			do_word.item_value  = req_q.new_value;
			do_word.entry_count = 5'(occ_q + CW'(1));
		end else if (do_remove) begin
			do_word.item_value  = cur_val;
			do_word.entry_count = 5'(occ_q - CW'(1));
		end else begin
			case (req_q.mode) inside
				MODE_CLEAR: do_word.entry_count = 5'd0;
				MODE_FRONT, MODE_END: do_word.status = ST_FULL;
				MODE_BEFORE: begin
					if (occ_q == '0)
						do_word.status = ST_EMPTY;
					else if (found_q)
						do_word.status = ST_MISS;
					else
						do_word.status = ST_FULL;
				end
				MODE_DROP_F, MODE_DROP_L, MODE_DROP_K:
					do_word.status = (occ_q == '0) ? ST_EMPTY : ST_MISS;
				MODE_SEARCH: begin
					if (occ_q == '0)
						do_word.status = ST_EMPTY;
					else if (found_q)
						do_word.status = ST_MISS;
					else
						do_word.item_value = req_q.key;
				end
				MODE_LIST: do_word.status = ST_EMPTY;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DO && do_insert)
			val_mem[free_q] <= req_q.new_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			for (int i = 0; i < CAPACITY; i++)
				link_q[i] <= (i + 1 < CAPACITY) ? IW'(i + 1) : '0;
			head_q      <= '0;
			tail_q      <= '0;
			free_q      <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
			prev_q      <= '0;
			step_q      <= '0;
			found_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (out_valid_q && !out_stall)
						out_valid_q <= 1'b0;
					if (in_valid && !in_stall) begin
						req_q   <= in_word;
						cur_q   <= head_q;
						prev_q  <= tail_q;
						step_q  <= '0;
						found_q <= 1'b0;
						if ((in_word.mode == MODE_BEFORE || in_word.mode == MODE_DROP_L
						     || in_word.mode == MODE_DROP_K || in_word.mode == MODE_SEARCH)
						    && occ_q != '0)
							state_q <= S_WALK;
						else if (in_word.mode == MODE_LIST && occ_q != '0)
							state_q <= S_LIST;
						else
							state_q <= S_DO;
					end
				end
				S_WALK: begin
					// found_q low here means hit; set high on a miss
					if (req_q.mode == MODE_DROP_L && occ_q == CW'(1)) begin
						cur_q   <= tail_q;
						prev_q  <= head_q;
						state_q <= S_DO;
					end else if (walk_hit) begin
						if (req_q.mode == MODE_DROP_L) begin
							prev_q <= cur_q;
							cur_q  <= tail_q;
						end
						state_q <= S_DO;
					end else if (step_q + CW'(1) == occ_q) begin
						found_q <= 1'b1;
						state_q <= S_DO;
					end else begin
						prev_q <= cur_q;
						cur_q  <= link_q[cur_q];
						step_q <= step_q + CW'(1);
					end
				end
				S_LIST: begin
					if (!out_valid_q || !out_stall) begin
						out_q       <= '{ST_OK, cur_val, occ5, step_q + CW'(1) == occ_q};
						out_valid_q <= 1'b1;
						cur_q       <= link_q[cur_q];
						step_q      <= step_q + CW'(1);
						if (step_q + CW'(1) == occ_q)
							state_q <= S_IDLE;
					end
				end
				S_DO: begin
					state_q <= S_OUT;
					out_q   <= do_word;
					if (req_q.mode == MODE_CLEAR) begin
						for (int i = 0; i < CAPACITY; i++)
							link_q[i] <= (i + 1 < CAPACITY) ? IW'(i + 1) : '0;
						head_q <= '0; tail_q <= '0; free_q <= '0; occ_q <= '0;
					end else if (do_insert) begin
						free_q <= link_q[free_q];
						if (occ_q == '0) begin
							head_q <= free_q; tail_q <= free_q;
							link_q[free_q] <= free_q;
						end else begin
							link_q[free_q] <= link_q[prev_q];
							link_q[prev_q] <= free_q;
							if (req_q.mode == MODE_END)
								tail_q <= free_q;
							else if (req_q.mode == MODE_FRONT || cur_q == head_q)
								head_q <= free_q;
						end
						occ_q <= occ_q + CW'(1);
					end else if (do_remove) begin
						if (occ_q == CW'(1)) begin
							head_q <= '0; tail_q <= '0;
						end else begin
							link_q[prev_q] <= link_q[cur_q];
							if (cur_q == head_q) head_q <= link_q[cur_q];
							if (cur_q == tail_q) tail_q <= prev_q;
						end
						link_q[cur_q] <= free_q;
						free_q <= cur_q;
						occ_q  <= occ_q - CW'(1);
					end
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(CAPACITY)) else $error("occupancy over capacity");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("input taken while busy");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_word)))
		else $error("output word changed under stall");
	a_list_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIST) |-> (step_q < occ_q)) else $error("list walk overran");
`endif

endmodule

[tb/circular_ordered_list_engine_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_ordered_list_engine_test
// Checks the circular list engine against an in-bench list predictor. Requests
// run through a queue-fed driver; each output word is compared by field with
// the oldest expected word. Both sides idle at random in bursts, and there is
// one long output hold-off so the engine stalls its input.
// ----------------------------------------------------------------------------
module circular_ordered_list_engine_test;
	import cole_pkg::*;

	localparam int CAP = 16;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	cole_in_t  in_word;
	logic      out_valid;
	logic      out_stall;
	cole_out_t out_word;

	circular_ordered_list_engine #(.CAPACITY(CAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
	);

	// Predictor state: the list held as an ordered array of values.
	logic signed [31:0] list_vals[$];
	cole_out_t          expected_words[$];
	cole_in_t           pending_reqs[$];
	int                 fail_count = 0;
	int                 words_seen = 0;
	int                 reqs_sent = 0;
	bit                 quiet = 0;
	bit                 hold_out = 0;
	int                 hold_cycles = 0;
	int                 in_gap = 0;
	int                 out_gap = 0;

	function automatic void push_word(logic [1:0] st, logic signed [31:0] v, bit fin);
		cole_out_t w;
		w.status      = st;
		w.item_value  = v;
		w.entry_count = 5'(list_vals.size());
		w.last        = fin;
		expected_words.push_back(w);
	endfunction

	function automatic int find_key(logic signed [31:0] k);
		for (int i = 0; i < list_vals.size(); i++)
			if (list_vals[i] == k) return i;
		return -1;
	endfunction

	function automatic void predict_list_op(cole_in_t r);
		int pos;
		logic signed [31:0] v;
		case (r.mode)
			MODE_CLEAR: begin
				list_vals.delete();
				push_word(ST_OK, 0, 1);
			end
			MODE_FRONT, MODE_END: begin
				if (list_vals.size() >= CAP) push_word(ST_FULL, 0, 1);
				else begin
					if (r.mode == MODE_FRONT) list_vals.push_front(r.new_value);
					else list_vals.push_back(r.new_value);
					push_word(ST_OK, r.new_value, 1);
				end
			end
			MODE_BEFORE: begin
				pos = find_key(r.key);
				if (list_vals.size() == 0) push_word(ST_EMPTY, 0, 1);
				else if (pos < 0) push_word(ST_MISS, 0, 1);
				else if (list_vals.size() >= CAP) push_word(ST_FULL, 0, 1);
				else begin
					list_vals.insert(pos, r.new_value);
					push_word(ST_OK, r.new_value, 1);
				end
			end
			MODE_DROP_F, MODE_DROP_L, MODE_DROP_K: begin
				if (list_vals.size() == 0) push_word(ST_EMPTY, 0, 1);
				else begin
					if (r.mode == MODE_DROP_F) pos = 0;
					else if (r.mode == MODE_DROP_L) pos = list_vals.size() - 1;
					else pos = find_key(r.key);
					if (pos < 0) push_word(ST_MISS, 0, 1);
					else begin
						v = list_vals[pos];
						list_vals.delete(pos);
						push_word(ST_OK, v, 1);
					end
				end
			end
			MODE_SEARCH: begin
				if (list_vals.size() == 0) push_word(ST_EMPTY, 0, 1);
				else if (find_key(r.key) >= 0) push_word(ST_OK, r.key, 1);
				else push_word(ST_MISS, 0, 1);
			end
			MODE_LIST: begin
				if (list_vals.size() == 0) push_word(ST_EMPTY, 0, 1);
				else
					for (int i = 0; i < list_vals.size(); i++)
						push_word(ST_OK, list_vals[i], i == list_vals.size() - 1);
			end
			default: push_word(ST_OK, 0, 1);
		endcase
	endfunction

	function automatic cole_in_t make_req(logic [3:0] m, logic signed [31:0] nv,
			logic signed [31:0] k);
		cole_in_t r;
		r.mode = m;
		r.new_value = nv;
		r.key = k;
		return r;
	endfunction

	// Values from a small pool so keys hit often; sometimes a full-range value.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'sh8000_0000;
			2: return 32'sh7fff_ffff;
			default: return 32'(int'($urandom_range(0, 11)) - 4);
		endcase
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("circular_ordered_list_engine: mismatch");
		$finish;
	end

	initial begin
		logic [3:0] m;
		// directed: empty cases, extremes, fill past full, every mode
		pending_reqs.push_back(make_req(MODE_LIST, 0, 0));
		pending_reqs.push_back(make_req(MODE_DROP_F, 0, 0));
		pending_reqs.push_back(make_req(MODE_DROP_L, 0, 0));
		pending_reqs.push_back(make_req(MODE_DROP_K, 0, 5));
		pending_reqs.push_back(make_req(MODE_SEARCH, 0, 5));
		pending_reqs.push_back(make_req(MODE_BEFORE, 1, 5));
		pending_reqs.push_back(make_req(MODE_FRONT, 32'sh7fff_ffff, 0));
		pending_reqs.push_back(make_req(MODE_END, 32'sh8000_0000, 32'sh7fff_ffff));
		pending_reqs.push_back(make_req(MODE_BEFORE, -1, 32'sh7fff_ffff));
		pending_reqs.push_back(make_req(MODE_BEFORE, 3, 99));
		pending_reqs.push_back(make_req(MODE_SEARCH, 0, 32'sh8000_0000));
		pending_reqs.push_back(make_req(MODE_SEARCH, 0, 7));
		pending_reqs.push_back(make_req(MODE_LIST, 0, 0));
		pending_reqs.push_back(make_req(4'd9, -1, -1));
		pending_reqs.push_back(make_req(4'd15, 0, 0));
		for (int i = 0; i < 14; i++) pending_reqs.push_back(make_req(MODE_END, i, 0));
		pending_reqs.push_back(make_req(MODE_FRONT, 1, 0));
		pending_reqs.push_back(make_req(MODE_BEFORE, 2, 3));
		pending_reqs.push_back(make_req(MODE_LIST, 0, 0));
		pending_reqs.push_back(make_req(MODE_DROP_L, 0, 0));
		pending_reqs.push_back(make_req(MODE_DROP_K, 0, 32'sh8000_0000));
		pending_reqs.push_back(make_req(MODE_DROP_K, 0, 1234));
		pending_reqs.push_back(make_req(MODE_DROP_F, 0, 0));
		pending_reqs.push_back(make_req(MODE_CLEAR, 0, 0));
		pending_reqs.push_back(make_req(MODE_LIST, 0, 0));
		for (int i = 0; i < 430; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: m = MODE_END;
				4, 5, 6:    m = MODE_FRONT;
				7, 8:       m = MODE_BEFORE;
				9:          m = MODE_DROP_F;
				10:         m = MODE_DROP_L;
				11, 12:     m = MODE_DROP_K;
				13, 14:     m = MODE_SEARCH;
				15, 16:     m = MODE_LIST;
				17:         m = ($urandom_range(0, 3) == 0) ? MODE_CLEAR : MODE_END;
				18:         m = 4'($urandom_range(9, 15));
				default:    m = 4'($urandom());
			endcase
			pending_reqs.push_back(make_req(m, pick_value(), pick_value()));
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_word  <= '0;
			in_gap   <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_list_op(in_word);
				reqs_sent <= reqs_sent + 1;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap   <= in_gap - 1;
					in_valid <= 0;
				end else if (!quiet && $urandom_range(0, 7) == 0) begin
					in_gap   <= $urandom_range(0, 4);
					in_valid <= 0;
				end else if (pending_reqs.size() > 0) begin
					in_word  <= pending_reqs.pop_front();
					in_valid <= 1;
				end else
					in_valid <= 0;
			end
		end
	end

	// receiver stall and checking
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1;
			out_gap   <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				words_seen <= words_seen + 1;
				if (expected_words.size() == 0) begin
					$error("unexpected word: status %0d value %0d", out_word.status,
						out_word.item_value);
					fail_count++;
				end else begin
					cole_out_t e;
					e = expected_words.pop_front();
					if (out_word.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, out_word.status);
						fail_count++;
					end
					if (out_word.item_value !== e.item_value) begin
						$error("item_value: expected %0d, got %0d", e.item_value,
							out_word.item_value);
						fail_count++;
					end
					if (out_word.entry_count !== e.entry_count) begin
						$error("entry_count: expected %0d, got %0d", e.entry_count,
							out_word.entry_count);
						fail_count++;
					end
					if (out_word.last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, out_word.last);
						fail_count++;
					end
				end
			end
			if (hold_out) begin
				out_stall <= 1;
			end else if (out_gap > 0) begin
				out_gap   <= out_gap - 1;
				out_stall <= 1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_gap   <= $urandom_range(0, 4);
				out_stall <= 1;
			end else
				out_stall <= 0;
		end
	end

	// long receiver hold-off while the sender keeps offering
	always @(posedge clk) begin
		if (arst_n && reqs_sent == 120 && hold_cycles == 0) begin
			hold_out    <= 1;
			hold_cycles <= 1;
		end else if (hold_cycles > 0 && hold_cycles < 300) begin
			hold_cycles <= hold_cycles + 1;
			if (hold_cycles == 299) hold_out <= 0;
		end
	end

	initial begin
		int waited;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		wait (reqs_sent > 350);
		quiet = 1;
		wait (pending_reqs.size() == 0 && !in_valid);
		waited = 0;
		while (expected_words.size() > 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_words.size() > 0) begin
			$error("%0d expected words never arrived", expected_words.size());
			fail_count++;
		end
		repeat (40) @(posedge clk);
		$display("Sent %0d requests over all modes incl. full/empty/missing-key cases,",
			reqs_sent);
		$display("checked %0d output words, with random idling and a long output hold-off.",
			words_seen);
		if (fail_count == 0)
			$display("circular_ordered_list_engine: match");
		else
			$display("circular_ordered_list_engine: mismatch");
		$finish;
	end

endmodule
